FILE: rtl/lmeoc_pkg.sv
// Shared types, constants and helper functions for the list-mode event order checker.
package lmeoc_pkg;

  localparam int NUM_MODULES = 7;
  localparam int SCALE_W     = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int WORD_W      = 32;
  localparam int EVLEN_W     = 13;
  localparam int EVLEN_LSB   = 17;
  localparam int HDRLEN_W    = 5;
  localparam int HDRLEN_LSB  = 12;
  localparam int CHAN_W      = 12;
  localparam int STAMP_HI_W  = 16;
  localparam int STAMP_W     = 48;
  localparam int SCALED_W    = 52;
  localparam int MOD_IDX_W   = 3;

  localparam logic [WORD_W-1:0] KEEP_HDR_MASK = 32'h8001_FFFF;
  localparam logic [WORD_W-1:0] LOW16_MASK    = 32'h0000_FFFF;

  // Channel address that maps to module 0 after the base offset.
  localparam logic [CHAN_W-1:0] MOD_BASE   = 12'd32;
  // Truncation toward zero folds base-15..base-1 into module 0.
  localparam logic [CHAN_W-1:0] MOD_LOW_OK = 12'd17;
  localparam int                MOD_SHIFT  = 4;

  localparam logic [WORD_W-1:0] SAT_MAX = 32'hFFFF_FFFF;

  // Word position within an event that carries the trace length and
  // baseline fields, trimmed to 16 bits when traces are removed.
  localparam logic [EVLEN_W-1:0] IDX_HEADER   = 13'd0;
  localparam logic [EVLEN_W-1:0] IDX_STAMP_LO = 13'd1;
  localparam logic [EVLEN_W-1:0] IDX_STAMP_HI = 13'd2;
  localparam logic [EVLEN_W-1:0] IDX_TRACE    = 13'd3;

  typedef logic [NUM_MODULES-1:0][SCALE_W-1:0] scale_arr_t;

  typedef struct packed {
    logic                 bad;
    logic [MOD_IDX_W-1:0] idx;
  } mod_sel_t;

  // Stage 1: parsed word, timestamp and selected scale.
  typedef struct packed {
    logic [WORD_W-1:0]  word;
    logic               word_valid;
    logic               last;
    logic               bad_module;
    logic               ferr;
    logic [STAMP_W-1:0] stamp;
    logic [SCALE_W-1:0] scale;
  } s1_t;

  // Stage 2: scaled timestamp ready for the order check.
  typedef struct packed {
    logic [WORD_W-1:0]   word;
    logic                word_valid;
    logic                last;
    logic                bad_module;
    logic                ferr;
    logic [SCALED_W-1:0] scaled;
  } s2_t;

  typedef struct packed {
    logic [WORD_W-1:0]   word;
    logic                word_valid;
    logic                end_of_event;
    logic                first_event;
    logic                in_order;
    logic                bad_module;
    logic                framing_error;
    logic [SCALED_W-1:0] scaled_timestamp;
    logic [WORD_W-1:0]   ordered_count;
    logic [WORD_W-1:0]   unordered_count;
    logic [WORD_W-1:0]   total_count;
  } result_t;

  function automatic mod_sel_t mod_lookup(input logic [CHAN_W-1:0] chan);
    mod_sel_t              sel;
    logic [CHAN_W-1:0]     off;
    off = chan - MOD_BASE;
    sel.bad = 1'b0;
    sel.idx = '0;
    if (chan < MOD_LOW_OK) begin
      sel.bad = 1'b1;
    end else if (chan < MOD_BASE) begin
      sel.idx = '0;
    end else if ((off >> MOD_SHIFT) >= CHAN_W'(NUM_MODULES)) begin
      sel.bad = 1'b1;
    end else begin
      sel.idx = off[MOD_SHIFT +: MOD_IDX_W];
    end
    return sel;
  endfunction

  function automatic logic [WORD_W-1:0] sat_inc(input logic [WORD_W-1:0] v);
    return (v == SAT_MAX) ? v : v + WORD_W'(1);
  endfunction

endpackage

FILE: rtl/list_mode_event_order_checker_core.sv
// Top level of the list-mode event deframer and timestamp order checker.
// Accepts one 32-bit list-mode word per clock on in_word (valid/ready) and
// returns at most one result per word. The three steps are parse and header
// rewrite, the 48x4 timestamp multiply, then the order compare and count
// update into the result register. Each of those three register stages
// holds one request and advances whenever the stage after it is free, so the
// sustained rate is one word per clock; a stalled result side backs up
// through the stages before in_ready drops. Trace words after the header
// produce no result except the event's final word. A header with zero event
// or header length produces a framing-error result, after which every
// incoming word is accepted and dropped until reset. The seven 4-bit scale
// registers are written through cfg_we/cfg_index/cfg_wdata; the user must
// write them only while idle, as the block itself does not enforce it; an
// index of 7 is ignored.
module list_mode_event_order_checker_core import lmeoc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // Input word stream
  input  logic [WORD_W-1:0]    in_word,
  input  logic                 in_valid,
  output logic                 in_ready,
  // Result stream
  output logic [WORD_W-1:0]    out_word,
  output logic                 out_word_valid,
  output logic                 out_end_of_event,
  output logic                 out_first_event,
  output logic                 out_in_order,
  output logic                 out_bad_module,
  output logic                 out_framing_error,
  output logic [SCALED_W-1:0]  out_scaled_timestamp,
  output logic [WORD_W-1:0]    out_ordered_count,
  output logic [WORD_W-1:0]    out_unordered_count,
  output logic [WORD_W-1:0]    out_total_count,
  output logic                 out_valid,
  input  logic                 out_ready,
  // Scale register writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SCALE_W-1:0]   cfg_wdata
);

  scale_arr_t scale_r;
  s1_t        s1_q;
  logic       s1_valid;
  logic       s1_ready;
  s2_t        s2_q;
  logic       s2_valid;
  logic       s2_ready;
  result_t    res;

  // Scale registers; reset to the standard per-module time constants.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= {4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd10, 4'd10};
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_MODULES))) begin
      scale_r[cfg_index] <= cfg_wdata;
    end
  end

  // Stage 1: frame the event, rewrite header words, pick the module scale.
  lmeoc_parse u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .scale    (scale_r),
    .s1_q     (s1_q),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready)
  );

  // Stage 2: scale the timestamp.
  lmeoc_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_q     (s1_q),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s2_q     (s2_q),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready)
  );

  // Stage 3: compare against the previous event and hold the result.
  lmeoc_order u_order (
    .clk       (clk),
    .rst_n     (rst_n),
    .s2_q      (s2_q),
    .s2_valid  (s2_valid),
    .s2_ready  (s2_ready),
    .res       (res),
    .res_valid (out_valid),
    .res_ready (out_ready)
  );

  assign out_word             = res.word;
  assign out_word_valid       = res.word_valid;
  assign out_end_of_event     = res.end_of_event;
  assign out_first_event      = res.first_event;
  assign out_in_order         = res.in_order;
  assign out_bad_module       = res.bad_module;
  assign out_framing_error    = res.framing_error;
  assign out_scaled_timestamp = res.scaled_timestamp;
  assign out_ordered_count    = res.ordered_count;
  assign out_unordered_count  = res.unordered_count;
  assign out_total_count      = res.total_count;

endmodule

FILE: rtl/lmeoc_parse.sv
// Event framer: tracks the word position, rewrites header words, builds the timestamp.
module lmeoc_parse import lmeoc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [WORD_W-1:0] in_word,
  input  logic              in_valid,
  output logic              in_ready,
  input  scale_arr_t        scale,
  output s1_t               s1_q,
  output logic              s1_valid,
  input  logic              s1_ready
);

  logic [EVLEN_W-1:0]    word_index_r;
  logic [EVLEN_W-1:0]    event_words_r;
  logic [HDRLEN_W-1:0]   header_words_r;
  mod_sel_t              mod_sel_r;
  logic [WORD_W-1:0]     stamp_low_r;
  logic [STAMP_HI_W-1:0] stamp_high_r;
  logic                  halted_r;
  s1_t                   s1_r;
  logic                  s1_valid_r;

  logic                  stage_free;
  logic                  work;
  logic                  hdr;
  logic [EVLEN_W-1:0]    ev_c;
  logic [HDRLEN_W-1:0]   hw_c;
  mod_sel_t              mod_c;
  logic [WORD_W-1:0]     st_lo_c;
  logic [STAMP_HI_W-1:0] st_hi_c;
  logic                  ferr;
  logic                  keep;
  logic                  last;
  logic                  stripped;
  logic                  emit;
  s1_t                   s1_nxt;

  assign stage_free = !s1_valid_r || s1_ready;
  // Drop words silently once halted.
  assign in_ready   = halted_r || stage_free;
  assign work       = in_valid && in_ready && !halted_r;

  always_comb begin
    hdr     = (word_index_r == IDX_HEADER);
    ev_c    = hdr ? in_word[EVLEN_LSB +: EVLEN_W] : event_words_r;
    hw_c    = hdr ? in_word[HDRLEN_LSB +: HDRLEN_W] : header_words_r;
    mod_c   = hdr ? mod_lookup(in_word[CHAN_W-1:0]) : mod_sel_r;
    st_lo_c = hdr ? '0 : ((word_index_r == IDX_STAMP_LO) ? in_word : stamp_low_r);
    st_hi_c = hdr ? '0 : ((word_index_r == IDX_STAMP_HI) ? in_word[STAMP_HI_W-1:0]
                                                           : stamp_high_r);
    ferr     = hdr && ((ev_c == '0) || (hw_c == '0));
    keep     = !ferr && (word_index_r < EVLEN_W'(hw_c));
    last     = !ferr && ((EVLEN_W+1)'(word_index_r) + (EVLEN_W+1)'(1)
                         >= (EVLEN_W+1)'(ev_c));
    stripped = (ev_c != EVLEN_W'(hw_c));
    emit     = ferr || keep || last;

    s1_nxt            = '0;
    s1_nxt.word_valid = keep;
    s1_nxt.last       = last;
    s1_nxt.ferr       = ferr;
    if (keep) begin
      if (stripped && hdr) begin
        s1_nxt.word = (WORD_W'(hw_c) << EVLEN_LSB) | (in_word & KEEP_HDR_MASK);
      end else if (stripped && (word_index_r == IDX_TRACE)) begin
        s1_nxt.word = in_word & LOW16_MASK;
      end else begin
        s1_nxt.word = in_word;
      end
    end
    if (last) begin
      s1_nxt.bad_module = mod_c.bad;
      s1_nxt.stamp      = {st_hi_c, st_lo_c};
      s1_nxt.scale      = mod_c.bad ? SCALE_W'(1) : scale[mod_c.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      halted_r       <= 1'b0;
      word_index_r   <= '0;
      event_words_r  <= '0;
      header_words_r <= '0;
      mod_sel_r      <= '0;
      stamp_low_r    <= '0;
      stamp_high_r   <= '0;
    end else begin
      if (stage_free) begin
        s1_valid_r <= work && emit;
      end
      if (work) begin
        if (ferr) begin
          halted_r <= 1'b1;
        end else begin
          word_index_r <= last ? '0 : word_index_r + EVLEN_W'(1);
        end
        if (hdr) begin
          event_words_r  <= ev_c;
          header_words_r <= hw_c;
          mod_sel_r      <= mod_c;
        end
        stamp_low_r  <= st_lo_c;
        stamp_high_r <= st_hi_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (work && emit) begin
      s1_r <= s1_nxt;
    end
  end

  assign s1_q     = s1_r;
  assign s1_valid = s1_valid_r;

  a_halt_no_new: assert property (@(posedge clk) disable iff (!rst_n)
    $past(halted_r) && rst_n && $past(rst_n) |-> !$rose(s1_valid_r))
    else $error("new request entered stage 1 while halted");
  a_s1_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (s1_r.word_valid || s1_r.last || s1_r.ferr))
    else $error("stage 1 holds a request that yields no result");
  a_ferr_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_r.ferr) |-> (!s1_r.word_valid && !s1_r.last))
    else $error("framing error combined with kept or final word");

endmodule

FILE: rtl/lmeoc_scale.sv
// Timestamp scaling stage: multiplies the 48-bit timestamp by the module constant.
module lmeoc_scale import lmeoc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  s1_t  s1_q,
  input  logic s1_valid,
  output logic s1_ready,
  output s2_t  s2_q,
  output logic s2_valid,
  input  logic s2_ready
);

  s2_t  s2_r;
  logic s2_valid_r;
  logic load;

  assign s1_ready = !s2_valid_r || s2_ready;
  assign load     = s1_valid && s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s2_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s2_r.word       <= s1_q.word;
      s2_r.word_valid <= s1_q.word_valid;
      s2_r.last       <= s1_q.last;
      s2_r.bad_module <= s1_q.bad_module;
      s2_r.ferr       <= s1_q.ferr;
      s2_r.scaled     <= SCALED_W'(s1_q.stamp) * SCALED_W'(s1_q.scale);
    end
  end

  assign s2_q     = s2_r;
  assign s2_valid = s2_valid_r;

endmodule

FILE: rtl/lmeoc_order.sv
// Order check: compares scaled timestamps, keeps saturating counts, holds the result register.
module lmeoc_order import lmeoc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  s2_t     s2_q,
  input  logic    s2_valid,
  output logic    s2_ready,
  output result_t res,
  output logic    res_valid,
  input  logic    res_ready
);

  logic                res_valid_r;
  logic [WORD_W-1:0]   word_r;
  logic                word_valid_r;
  logic                eoe_r;
  logic                first_r;
  logic                in_order_r;
  logic                bad_module_r;
  logic                ferr_r;
  logic [SCALED_W-1:0] scaled_r;
  logic [SCALED_W-1:0] prev_r;
  logic                seen_first_r;
  logic [WORD_W-1:0]   ok_total_r;
  logic [WORD_W-1:0]   bad_total_r;
  logic [WORD_W-1:0]   all_total_r;

  logic take;
  logic cmp;
  logic ge;

  assign s2_ready = !res_valid_r || res_ready;
  assign take     = s2_valid && s2_ready;
  assign cmp      = s2_q.last && seen_first_r;
  assign ge       = (s2_q.scaled >= prev_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r  <= 1'b0;
      seen_first_r <= 1'b0;
      prev_r       <= '0;
      ok_total_r   <= '0;
      bad_total_r  <= '0;
      all_total_r  <= '0;
    end else begin
      if (s2_ready) begin
        res_valid_r <= s2_valid;
      end
      if (take && s2_q.last) begin
        seen_first_r <= 1'b1;
        prev_r       <= s2_q.scaled;
      end
      if (take && cmp) begin
        if (ge) begin
          ok_total_r <= sat_inc(ok_total_r);
        end else begin
          bad_total_r <= sat_inc(bad_total_r);
        end
        all_total_r <= sat_inc(all_total_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      word_r       <= s2_q.word;
      word_valid_r <= s2_q.word_valid;
      eoe_r        <= s2_q.last;
      first_r      <= s2_q.last && !seen_first_r;
      in_order_r   <= cmp && ge;
      bad_module_r <= s2_q.bad_module;
      ferr_r       <= s2_q.ferr;
      scaled_r     <= s2_q.scaled;
    end
  end

  // Counters only move when a request enters the result register, so
  // they always match the result on display.
  always_comb begin
    res.word             = word_r;
    res.word_valid       = word_valid_r;
    res.end_of_event     = eoe_r;
    res.first_event      = first_r;
    res.in_order         = in_order_r;
    res.bad_module       = bad_module_r;
    res.framing_error    = ferr_r;
    res.scaled_timestamp = scaled_r;
    res.ordered_count    = ok_total_r;
    res.unordered_count  = bad_total_r;
    res.total_count      = all_total_r;
  end

  assign res_valid = res_valid_r;

  a_flags_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && (first_r || in_order_r)) |-> (eoe_r && !(first_r && in_order_r)))
    else $error("first/in_order flag off an event end");
  a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && $past(rst_n)) |-> (all_total_r >= $past(all_total_r)))
    else $error("total count went backward");
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (all_total_r >= ok_total_r) && (all_total_r >= bad_total_r))
    else $error("total count below a partial count");

endmodule
